### src/iftc_pkg.sv
// Package: shared constants, codes and types of the interconnect flow traffic counters.
package iftc_pkg;

    localparam int MAX_MASTERS = 8;
    localparam int MAX_SLAVES  = 8;
    localparam int COUNT_BITS  = 32;
    localparam int BYTE_BITS   = 48;
    localparam int OUT_BITS    = 32;

    localparam int FLOWS  = 2 * MAX_MASTERS * MAX_SLAVES;
    localparam int ADDR_W = $clog2(FLOWS);

    typedef enum logic [2:0] {
        OP_REC_REQ   = 3'd0,
        OP_REC_RSP   = 3'd1,
        OP_QUERY_REQ = 3'd2,
        OP_QUERY_RSP = 3'd3,
        OP_CLEAR     = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_OTHER = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_MASTER_COUNT = 2'd0,
        CFG_SLAVE_COUNT  = 2'd1,
        CFG_HEADER_BYTES = 2'd2
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [COUNT_BITS-1:0] rd_cnt;
        logic [COUNT_BITS-1:0] wr_cnt;
        logic [COUNT_BITS-1:0] oth_cnt;
        logic [COUNT_BITS-1:0] trn_cnt;
        logic [BYTE_BITS-1:0]  byte_sum;
    } t_flow;

    typedef struct packed {
        logic              en;
        logic              clear;
        logic [ADDR_W-1:0] addr;
        t_flow             data;
    } t_store_wr;

endpackage

### src/iftc_in_if.sv
// Interface: input item channel carrying one traffic event or command.
interface iftc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [2:0] master_id;
    logic [2:0] target_id;
    logic [1:0] cmd_kind;
    logic [9:0] byte_count;

    modport source (output valid, opcode, master_id, target_id, cmd_kind, byte_count,
                    input ready);
    modport sink   (input valid, opcode, master_id, target_id, cmd_kind, byte_count,
                    output ready);
endinterface

### src/iftc_out_if.sv
// Interface: result item channel carrying the error flag and flow counters.
interface iftc_out_if;
    logic        valid;
    logic        ready;
    logic        error;
    logic [31:0] read_total;
    logic [31:0] write_total;
    logic [31:0] other_total;
    logic [31:0] transaction_total;
    logic [47:0] byte_total;

    modport source (output valid, error, read_total, write_total, other_total,
                    transaction_total, byte_total, input ready);
    modport sink   (input valid, error, read_total, write_total, other_total,
                    transaction_total, byte_total, output ready);
endinterface

### src/iftc_flow_store.sv
// Flow counter memory with per-entry valid bits for reset and clear.
module iftc_flow_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [iftc_pkg::ADDR_W-1:0] i_rd_addr,
    input  iftc_pkg::t_store_wr         i_wr,
    output iftc_pkg::t_flow             o_rd_data
);

    iftc_pkg::t_flow             r_mem [iftc_pkg::FLOWS];
    logic [iftc_pkg::FLOWS-1:0]  r_valid;
    iftc_pkg::t_flow             r_rd_data;
    logic                        r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### src/interconnect_flow_traffic_counters.sv
// Top level: per-flow traffic counters with record, query and clear operations.
//
//  channel   direction  handshake      payload
//  i_req     in         valid/ready    opcode, master_id, target_id, cmd_kind, byte_count
//  o_res     out        valid/ready    error, read/write/other/transaction totals, byte_total
//  i_cfg_*   in         write enable   index, data (master_count, slave_count, header_bytes)
//
//  For each item, the flow entry is read from memory in the accept cycle, then updated,
//  written back and registered as the result in the execute state.
//  One item is in flight at a time; the next is accepted once the write-back is done.
//  A full result register stalls the write-back cycle until the result is taken.
//  Reset and the clear operation zero every flow at once through per-entry valid bits.
module interconnect_flow_traffic_counters (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    iftc_in_if.sink     i_req,
    iftc_out_if.source  o_res
);

    localparam logic [iftc_pkg::ADDR_W-1:0] SLV_A  = iftc_pkg::ADDR_W'(iftc_pkg::MAX_SLAVES);
    localparam logic [iftc_pkg::ADDR_W-1:0] MST_A  = iftc_pkg::ADDR_W'(iftc_pkg::MAX_MASTERS);
    localparam logic [iftc_pkg::ADDR_W-1:0] RSP_A  =
        iftc_pkg::ADDR_W'(iftc_pkg::MAX_MASTERS * iftc_pkg::MAX_SLAVES);

    logic [3:0]                  r_master_count;
    logic [3:0]                  r_slave_count;
    logic [7:0]                  r_header_bytes;

    iftc_pkg::t_state            r_state;
    iftc_pkg::t_state            n_state;

    logic [2:0]                  r_op;
    logic [1:0]                  r_kind;
    logic [9:0]                  r_nbytes;
    logic                        r_err;
    logic                        r_resp;
    logic [iftc_pkg::ADDR_W-1:0] r_idx;

    logic                        r_out_valid;
    logic                        r_out_error;
    logic [31:0]                 r_out_read;
    logic [31:0]                 r_out_write;
    logic [31:0]                 r_out_other;
    logic [31:0]                 r_out_trn;
    logic [47:0]                 r_out_bytes;

    logic                        in_acc;
    logic                        go;
    logic                        in_resp;
    logic                        in_idx_op;
    logic                        id_bad;
    logic [iftc_pkg::ADDR_W-1:0] in_idx;

    logic                        is_rec;
    logic                        is_query;
    logic [10:0]                 add_bytes;
    iftc_pkg::t_flow             rd_flow;
    iftc_pkg::t_flow             upd_flow;
    iftc_pkg::t_store_wr         st_wr;

    logic                        n_out_error;
    logic [31:0]                 n_out_read;
    logic [31:0]                 n_out_write;
    logic [31:0]                 n_out_other;
    logic [31:0]                 n_out_trn;
    logic [47:0]                 n_out_bytes;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_count <= 4'd8;
            r_slave_count  <= 4'd8;
            r_header_bytes <= 8'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                iftc_pkg::CFG_MASTER_COUNT: r_master_count <= i_cfg_data[3:0];
                iftc_pkg::CFG_SLAVE_COUNT:  r_slave_count  <= i_cfg_data[3:0];
                iftc_pkg::CFG_HEADER_BYTES: r_header_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept side: range check and flow address
    assign in_acc    = i_req.valid && i_req.ready;
    assign in_resp   = (i_req.opcode == iftc_pkg::OP_REC_RSP) ||
                       (i_req.opcode == iftc_pkg::OP_QUERY_RSP);
    assign in_idx_op = (i_req.opcode == iftc_pkg::OP_REC_REQ) ||
                       (i_req.opcode == iftc_pkg::OP_REC_RSP) ||
                       (i_req.opcode == iftc_pkg::OP_QUERY_REQ) ||
                       (i_req.opcode == iftc_pkg::OP_QUERY_RSP);
    assign id_bad    = ({1'b0, i_req.master_id} >= r_master_count) ||
                       (32'(i_req.master_id) >= 32'(iftc_pkg::MAX_MASTERS)) ||
                       ({1'b0, i_req.target_id} >= r_slave_count) ||
                       (32'(i_req.target_id) >= 32'(iftc_pkg::MAX_SLAVES));

    always_comb begin
        if (in_resp) begin
            in_idx = iftc_pkg::ADDR_W'(RSP_A + iftc_pkg::ADDR_W'(i_req.target_id) * MST_A
                                       + iftc_pkg::ADDR_W'(i_req.master_id));
        end else begin
            in_idx = iftc_pkg::ADDR_W'(iftc_pkg::ADDR_W'(i_req.master_id) * SLV_A
                                       + iftc_pkg::ADDR_W'(i_req.target_id));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_req.opcode;
            r_kind   <= i_req.cmd_kind;
            r_nbytes <= i_req.byte_count;
            r_err    <= in_idx_op && id_bad;
            r_resp   <= in_resp;
            r_idx    <= in_idx;
        end
    end

    iftc_flow_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_idx),
        .i_wr      (st_wr),
        .o_rd_data (rd_flow)
    );

    // sequencer
    assign go = (r_state == iftc_pkg::ST_EXEC) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iftc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            iftc_pkg::ST_IDLE: if (in_acc) n_state = iftc_pkg::ST_EXEC;
            iftc_pkg::ST_EXEC: if (go)     n_state = iftc_pkg::ST_IDLE;
            default:                       n_state = iftc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            iftc_pkg::ST_IDLE: i_req.ready = 1'b1;
            default:           i_req.ready = 1'b0;
        endcase
    end

    // update and result
    assign is_rec   = !r_err && ((r_op == iftc_pkg::OP_REC_REQ) ||
                                 (r_op == iftc_pkg::OP_REC_RSP));
    assign is_query = !r_err && ((r_op == iftc_pkg::OP_QUERY_REQ) ||
                                 (r_op == iftc_pkg::OP_QUERY_RSP));

    always_comb begin
        add_bytes = {3'd0, r_header_bytes};
        upd_flow  = rd_flow;
        upd_flow.trn_cnt = rd_flow.trn_cnt + 1'b1;
        case (r_kind)
            iftc_pkg::KIND_READ: begin
                upd_flow.rd_cnt = rd_flow.rd_cnt + 1'b1;
                if (r_resp) add_bytes = add_bytes + {1'b0, r_nbytes};
            end
            iftc_pkg::KIND_WRITE: begin
                upd_flow.wr_cnt = rd_flow.wr_cnt + 1'b1;
                if (!r_resp) add_bytes = add_bytes + {1'b0, r_nbytes};
            end
            default: upd_flow.oth_cnt = rd_flow.oth_cnt + 1'b1;
        endcase
        upd_flow.byte_sum = rd_flow.byte_sum + iftc_pkg::BYTE_BITS'(add_bytes);
    end

    always_comb begin
        st_wr.en    = go && is_rec;
        st_wr.clear = go && (r_op == iftc_pkg::OP_CLEAR);
        st_wr.addr  = r_idx;
        st_wr.data  = upd_flow;
    end

    always_comb begin
        n_out_error = r_err;
        n_out_read  = '0;
        n_out_write = '0;
        n_out_other = '0;
        n_out_trn   = '0;
        n_out_bytes = '0;
        if (is_query) begin
            n_out_read  = iftc_pkg::OUT_BITS'(rd_flow.rd_cnt);
            n_out_write = iftc_pkg::OUT_BITS'(rd_flow.wr_cnt);
            n_out_other = iftc_pkg::OUT_BITS'(rd_flow.oth_cnt);
            n_out_trn   = iftc_pkg::OUT_BITS'(rd_flow.trn_cnt);
            n_out_bytes = rd_flow.byte_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_error <= n_out_error;
            r_out_read  <= n_out_read;
            r_out_write <= n_out_write;
            r_out_other <= n_out_other;
            r_out_trn   <= n_out_trn;
            r_out_bytes <= n_out_bytes;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.error             = r_out_error;
    assign o_res.read_total        = r_out_read;
    assign o_res.write_total       = r_out_write;
    assign o_res.other_total       = r_out_other;
    assign o_res.transaction_total = r_out_trn;
    assign o_res.byte_total        = r_out_bytes;

endmodule

### src/iftc_checker.sv
// Checker: port-level assertions for the flow traffic counters, bound to the top level.
module iftc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_error,
    input logic [31:0] i_out_read,
    input logic [31:0] i_out_write,
    input logic [31:0] i_out_other,
    input logic [31:0] i_out_trn,
    input logic [47:0] i_out_bytes
);

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bytes) &&
                                        $stable(i_out_trn))
        else $error("result dropped or changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("item accepted while another is in flight");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> (i_out_read == '0) && (i_out_write == '0) &&
            (i_out_other == '0) && (i_out_trn == '0) && (i_out_bytes == '0))
        else $error("error result carries nonzero counters");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented after reset");

endmodule

bind interconnect_flow_traffic_counters iftc_checker u_iftc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_error (o_res.error),
    .i_out_read  (o_res.read_total),
    .i_out_write (o_res.write_total),
    .i_out_other (o_res.other_total),
    .i_out_trn   (o_res.transaction_total),
    .i_out_bytes (o_res.byte_total)
);
